[hdl/prc_pkg.sv]
package prc_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	localparam logic [3:0] CODE_LEFT  = 4'd1;
	localparam logic [3:0] CODE_RIGHT = 4'd2;
	localparam logic [3:0] CODE_BOT   = 4'd4;
	localparam logic [3:0] CODE_TOP   = 4'd8;
	localparam logic [3:0] CODE_HORZ  = CODE_LEFT | CODE_RIGHT;
	localparam logic [3:0] CODE_VERT  = CODE_BOT | CODE_TOP;
	localparam logic [3:0] CODE_IN    = 4'd0;

	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MAX_X = 2'd1;
	localparam logic [1:0] REG_MIN_Y = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECIDE = 10'b00_0000_0010,
		S_CX     = 10'b00_0000_0100,
		S_WX     = 10'b00_0000_1000,
		S_RC     = 10'b00_0001_0000,
		S_CY     = 10'b00_0010_0000,
		S_WY     = 10'b00_0100_0000,
		S_CD     = 10'b00_1000_0000,
		S_FIN    = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} ctl_state_t;

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL  = 4'b0010,
		U_DIV  = 4'b0100,
		U_SUM  = 4'b1000
	} unit_state_t;

	typedef enum logic [1:0] {
		M_ENTER   = 2'd0,
		M_LEAVE   = 2'd1,
		M_CROSS_A = 2'd2,
		M_CROSS_B = 2'd3
	} clip_mode_t;

endpackage

[hdl/prc_vert_if.sv]
interface prc_vert_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] vert_x;
	logic signed [W-1:0] vert_y;
	logic                line_first;
	logic                line_final;

	modport source (output valid, vert_x, vert_y, line_first, line_final, input ready);
	modport sink (input valid, vert_x, vert_y, line_first, line_final, output ready);
endinterface

[hdl/prc_pt_if.sv]
interface prc_pt_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] pt_x;
	logic signed [W-1:0] pt_y;
	logic                piece_begin;
	logic                piece_finish;
	logic                item_done;

	modport source (output valid, pt_x, pt_y, piece_begin, piece_finish, item_done,
		input ready);
	modport sink (input valid, pt_x, pt_y, piece_begin, piece_finish, item_done,
		output ready);
endinterface

[hdl/prc_shift_unit.sv]
module prc_shift_unit import prc_pkg::*; #(
	parameter int W = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] cv,
	input  logic signed [W-1:0] pv,
	input  logic signed [W-1:0] qv,
	input  logic signed [W-1:0] edge_v,
	input  logic signed [W-1:0] cu,
	input  logic signed [W-1:0] pu,
	input  logic signed [W-1:0] qu,
	output logic                done,
	output logic signed [W-1:0] res
);
	// res = cv + (pv-qv)*(edge_v-cu)/(pu-qu), truncated, saturated
	localparam int PWID = 2*W + 2;
	localparam int CW   = $clog2(PWID);

	unit_state_t          state_q;
	logic [W:0]           n1m_q, n2m_q, ddm_q, q_q, rem_q;
	logic                 neg_q, ovf_q;
	logic signed [W-1:0]  cv_q;
	logic [PWID-1:0]      prod_q;
	logic [CW-1:0]        cnt_q;

	logic signed [W:0]    n1, n2, dd;
	logic [W+1:0]         rem_sh;
	logic                 take;
	logic signed [W+2:0]  sum;
	logic signed [W+2:0]  smax, smin;

	assign n1 = (W+1)'(pv) - (W+1)'(qv);
	assign n2 = (W+1)'(edge_v) - (W+1)'(cu);
	assign dd = (W+1)'(pu) - (W+1)'(qu);

	assign rem_sh = {rem_q, prod_q[PWID-1]};
	assign take   = rem_sh >= {1'b0, ddm_q};

	assign smax = (W+3)'({1'b0, {(W-1){1'b1}}});
	assign smin = -smax - (W+3)'(1);
	assign sum  = neg_q ? (W+3)'(cv_q) - $signed({2'b00, q_q})
	                    : (W+3)'(cv_q) + $signed({2'b00, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done    <= 1'b0;
		end else begin
			done <= (state_q == U_SUM);
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						n1m_q   <= n1[W] ? (W+1)'(-n1) : n1;
						n2m_q   <= n2[W] ? (W+1)'(-n2) : n2;
						ddm_q   <= dd[W] ? (W+1)'(-dd) : dd;
						neg_q   <= (n1[W] ^ n2[W]) ^ dd[W];
						cv_q    <= cv;
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					prod_q <= PWID'(n1m_q) * PWID'(n2m_q);
					rem_q  <= '0;
					q_q    <= '0;
					ovf_q  <= 1'b0;
					cnt_q  <= '0;
					if (ddm_q == '0)
						state_q <= U_SUM;
					else
						state_q <= U_DIV;
				end
				U_DIV: begin
					prod_q <= {prod_q[PWID-2:0], 1'b0};
					rem_q  <= take ? (W+1)'(rem_sh - {1'b0, ddm_q}) : (W+1)'(rem_sh);
					q_q    <= {q_q[W-1:0], take};
					ovf_q  <= ovf_q | q_q[W];
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(PWID - 1))
						state_q <= U_SUM;
				end
				U_SUM: begin
					priority if (ovf_q)
						res <= neg_q ? W'(smin) : W'(smax);
					else if (sum > smax)
						res <= W'(smax);
					else if (sum < smin)
						res <= W'(smin);
					else
						res <= W'(sum);
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

endmodule

[hdl/polyline_rect_clipper_core.sv]
// Streaming polyline clipper against a programmable rectangle (Cohen-Sutherland
// outcodes, signed fixed point). Each accepted vertex closes a segment with the
// previous one and yields zero, one or two points, the last flagged item_done.
// Each clipped endpoint adds its edge steps; every edge step (at most four per
// segment) runs through one shared multiply/divide unit, whose restoring divider
// yields one bit per cycle. The input is not ready while a vertex is in work.
module polyline_rect_clipper_core import prc_pkg::*; #(
	parameter int  COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int PW          = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int AW          = (COORD_WIDTH > 32) ? 5 : 4
) (
	input  logic          clk,
	input  logic          arst_n,
	prc_vert_if.sink      vert,
	prc_pt_if.source      pt,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [PW-1:0] pwdata,
	output logic [PW-1:0] prdata,
	output logic          pready
);
	localparam int W = COORD_WIDTH;

	ctl_state_t          state_q;
	clip_mode_t          mode_q;
	logic signed [W-1:0] rmin_x_q, rmax_x_q, rmin_y_q, rmax_y_q;
	logic signed [W-1:0] prev_x_q, prev_y_q;
	logic [3:0]          prev_code_q;
	logic                have_prev_q, piece_open_q;
	logic signed [W-1:0] x_q, y_q, cx_q, cy_q;
	logic                first_q, final_q;
	logic [3:0]          code_q, ck_q;
	logic signed [W-1:0] rx_q [2];
	logic signed [W-1:0] ry_q [2];
	logic                rb_q [2];
	logic                rf_q [2];
	logic [1:0]          cnt_q;
	logic                idx_q;

	logic                unit_start, unit_done, ysel;
	logic signed [W-1:0] unit_res, edge_x, edge_y;
	logic [1:0]          reg_idx;

	function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y);
		logic [3:0] k;
		k = CODE_IN;
		if (x < rmin_x_q) k = k | CODE_LEFT;
		if (x > rmax_x_q) k = k | CODE_RIGHT;
		if (y < rmin_y_q) k = k | CODE_BOT;
		if (y > rmax_y_q) k = k | CODE_TOP;
		return k;
	endfunction

	function automatic logic signed [W-1:0] clampv(input logic signed [W-1:0] v,
		input logic signed [W-1:0] lo, input logic signed [W-1:0] hi);
		priority if (v < lo) return lo;
		else if (v > hi) return hi;
		else return v;
	endfunction

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1:AW-2];

	always_comb begin
		unique case (reg_idx)
			REG_MIN_X: prdata = PW'(rmin_x_q);
			REG_MAX_X: prdata = PW'(rmax_x_q);
			REG_MIN_Y: prdata = PW'(rmin_y_q);
			REG_MAX_Y: prdata = PW'(rmax_y_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_x_q <= '0;
			rmax_x_q <= '0;
			rmin_y_q <= '0;
			rmax_y_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MIN_X: rmin_x_q <= pwdata[W-1:0];
				REG_MAX_X: rmax_x_q <= pwdata[W-1:0];
				REG_MIN_Y: rmin_y_q <= pwdata[W-1:0];
				REG_MAX_Y: rmax_y_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	// edge step unit
	assign edge_x     = ((ck_q & CODE_LEFT) != CODE_IN) ? rmin_x_q : rmax_x_q;
	assign edge_y     = ((ck_q & CODE_BOT) != CODE_IN) ? rmin_y_q : rmax_y_q;
	assign ysel       = (state_q == S_CY);
	assign unit_start = ((state_q == S_CX) && ((ck_q & CODE_HORZ) != CODE_IN)) ||
	                    ((state_q == S_CY) && ((ck_q & CODE_VERT) != CODE_IN));

	prc_shift_unit #(.W(W)) u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.cv     (ysel ? cx_q : cy_q),
		.pv     (ysel ? prev_x_q : prev_y_q),
		.qv     (ysel ? x_q : y_q),
		.edge_v (ysel ? edge_y : edge_x),
		.cu     (ysel ? cy_q : cx_q),
		.pu     (ysel ? prev_y_q : prev_x_q),
		.qu     (ysel ? y_q : x_q),
		.done   (unit_done),
		.res    (unit_res)
	);

	// handshake
	assign vert.ready      = (state_q == S_IDLE);
	assign pt.valid        = (state_q == S_OUT);
	assign pt.pt_x         = rx_q[idx_q];
	assign pt.pt_y         = ry_q[idx_q];
	assign pt.piece_begin  = rb_q[idx_q];
	assign pt.piece_finish = rf_q[idx_q];
	assign pt.item_done    = idx_q || (cnt_q == 2'd1);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && vert.valid) begin
			x_q     <= vert.vert_x;
			y_q     <= vert.vert_y;
			first_q <= vert.line_first;
			final_q <= vert.line_final;
			code_q  <= outcode(vert.vert_x, vert.vert_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_ENTER;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_code_q  <= CODE_IN;
			have_prev_q  <= 1'b0;
			piece_open_q <= 1'b0;
			cnt_q        <= '0;
			idx_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (vert.valid)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					priority if (first_q && have_prev_q) begin
						rx_q[0] <= prev_x_q;
						ry_q[0] <= prev_y_q;
						rb_q[0] <= 1'b0;
						rf_q[0] <= 1'b1;
						cnt_q        <= piece_open_q ? 2'd1 : 2'd0;
						piece_open_q <= 1'b0;
						state_q      <= S_FIN;
					end else if (!have_prev_q) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else if (prev_code_q == CODE_IN && code_q == CODE_IN) begin
						rx_q[0] <= prev_x_q;
						ry_q[0] <= prev_y_q;
						rb_q[0] <= !piece_open_q;
						rf_q[0] <= 1'b0;
						rx_q[1] <= x_q;
						ry_q[1] <= y_q;
						rb_q[1] <= 1'b0;
						rf_q[1] <= 1'b1;
						cnt_q        <= final_q ? 2'd2 : 2'd1;
						piece_open_q <= !final_q;
						state_q      <= S_FIN;
					end else if (code_q == CODE_IN) begin
						cx_q    <= prev_x_q;
						cy_q    <= prev_y_q;
						ck_q    <= prev_code_q;
						mode_q  <= M_ENTER;
						state_q <= S_CX;
					end else if (prev_code_q == CODE_IN) begin
						rx_q[0] <= prev_x_q;
						ry_q[0] <= prev_y_q;
						rb_q[0] <= !piece_open_q;
						rf_q[0] <= 1'b0;
						cx_q    <= x_q;
						cy_q    <= y_q;
						ck_q    <= code_q;
						mode_q  <= M_LEAVE;
						state_q <= S_CX;
					end else if ((prev_code_q & code_q) == CODE_IN) begin
						cx_q    <= prev_x_q;
						cy_q    <= prev_y_q;
						ck_q    <= prev_code_q;
						mode_q  <= M_CROSS_A;
						state_q <= S_CX;
					end else begin
						cnt_q        <= '0;
						piece_open_q <= 1'b0;
						state_q      <= S_FIN;
					end
				end
				S_CX: begin
					if ((ck_q & CODE_HORZ) != CODE_IN)
						state_q <= S_WX;
					else
						state_q <= S_CY;
				end
				S_WX: begin
					if (unit_done) begin
						cy_q    <= unit_res;
						cx_q    <= edge_x;
						state_q <= S_RC;
					end
				end
				S_RC: begin
					ck_q    <= outcode(cx_q, cy_q);
					state_q <= S_CY;
				end
				S_CY: begin
					if ((ck_q & CODE_VERT) != CODE_IN)
						state_q <= S_WY;
					else
						state_q <= S_CD;
				end
				S_WY: begin
					if (unit_done) begin
						cx_q    <= unit_res;
						cy_q    <= edge_y;
						state_q <= S_CD;
					end
				end
				S_CD: begin
					unique case (mode_q)
						M_ENTER: begin
							rx_q[0] <= clampv(cx_q, rmin_x_q, rmax_x_q);
							ry_q[0] <= clampv(cy_q, rmin_y_q, rmax_y_q);
							rb_q[0] <= 1'b1;
							rf_q[0] <= 1'b0;
							rx_q[1] <= x_q;
							ry_q[1] <= y_q;
							rb_q[1] <= 1'b0;
							rf_q[1] <= 1'b1;
							cnt_q        <= final_q ? 2'd2 : 2'd1;
							piece_open_q <= !final_q;
							state_q      <= S_FIN;
						end
						M_CROSS_A: begin
							if (outcode(cx_q, cy_q) == CODE_IN) begin
								rx_q[0] <= cx_q;
								ry_q[0] <= cy_q;
								rb_q[0] <= 1'b1;
								rf_q[0] <= 1'b0;
								cx_q    <= x_q;
								cy_q    <= y_q;
								ck_q    <= code_q;
								mode_q  <= M_CROSS_B;
								state_q <= S_CX;
							end else begin
								cnt_q        <= '0;
								piece_open_q <= 1'b0;
								state_q      <= S_FIN;
							end
						end
						M_LEAVE, M_CROSS_B: begin
							rx_q[1] <= clampv(cx_q, rmin_x_q, rmax_x_q);
							ry_q[1] <= clampv(cy_q, rmin_y_q, rmax_y_q);
							rb_q[1] <= 1'b0;
							rf_q[1] <= 1'b1;
							cnt_q        <= 2'd2;
							piece_open_q <= 1'b0;
							state_q      <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					prev_x_q    <= x_q;
					prev_y_q    <= y_q;
					prev_code_q <= code_q;
					have_prev_q <= !final_q;
					if (final_q)
						piece_open_q <= 1'b0;
					idx_q   <= 1'b0;
					state_q <= (cnt_q == 2'd0) ? S_IDLE : S_OUT;
				end
				S_OUT: begin
					if (pt.ready) begin
						if (pt.item_done)
							state_q <= S_IDLE;
						else
							idx_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == S_WX || state_q == S_WY))
		else $error("edge step result arrived with no step pending");
	a_out_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		pt.valid |-> (cnt_q != 2'd0))
		else $error("point request with empty result buffer");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(vert.ready && pt.valid))
		else $error("vertex taken while points pending");
	a_second_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && idx_q) |-> (cnt_q == 2'd2))
		else $error("second point sent from single-point result");
`endif

endmodule
